// File: sv/stsc_pkg.sv
// Shared types, token codes and keyword table for the script token scanner.
`timescale 1ns / 1ps
`default_nettype none
package stsc_pkg;

  localparam int OFFSET_BITS_DEF     = 16;
  localparam int MAX_KEYWORD_LEN_DEF = 6;
  localparam int QUEUE_DEPTH         = 4;
  localparam int QUEUE_AW            = $clog2(QUEUE_DEPTH);
  localparam int KW_BITS             = 64;

  // token kinds
  localparam logic [5:0] K_LPAREN  = 6'd0;
  localparam logic [5:0] K_RPAREN  = 6'd1;
  localparam logic [5:0] K_LBRACE  = 6'd2;
  localparam logic [5:0] K_RBRACE  = 6'd3;
  localparam logic [5:0] K_COMMA   = 6'd4;
  localparam logic [5:0] K_DOT     = 6'd5;
  localparam logic [5:0] K_MINUS   = 6'd6;
  localparam logic [5:0] K_PLUS    = 6'd7;
  localparam logic [5:0] K_SEMI    = 6'd8;
  localparam logic [5:0] K_SLASH   = 6'd9;
  localparam logic [5:0] K_STAR    = 6'd10;
  localparam logic [5:0] K_BANG    = 6'd11;
  localparam logic [5:0] K_EQUAL   = 6'd13;
  localparam logic [5:0] K_GREATER = 6'd15;
  localparam logic [5:0] K_LESS    = 6'd17;
  localparam logic [5:0] K_IDENT   = 6'd19;
  localparam logic [5:0] K_STRING  = 6'd20;
  localparam logic [5:0] K_NUMBER  = 6'd21;
  localparam logic [5:0] K_KW0     = 6'd22;
  localparam logic [5:0] K_END     = 6'd38;
  localparam logic [5:0] K_BADCHAR = 6'd39;
  localparam logic [5:0] K_UNTERM  = 6'd40;

  // operator codes held while waiting for a possible '='
  localparam logic [1:0] OP_BANG    = 2'd0;
  localparam logic [1:0] OP_EQUAL   = 2'd1;
  localparam logic [1:0] OP_GREATER = 2'd2;
  localparam logic [1:0] OP_LESS    = 2'd3;

  localparam logic [15:0][KW_BITS-1:0] KW_TABLE = {
    64'h7768696c65,   // while
    64'h766172,       // var
    64'h74727565,     // true
    64'h74686973,     // this
    64'h7375706572,   // super
    64'h72657475726e, // return
    64'h7072696e74,   // print
    64'h6f72,         // or
    64'h6e696c,       // nil
    64'h6966,         // if
    64'h666f72,       // for
    64'h66756e,       // fun
    64'h66616c7365,   // false
    64'h656c7365,     // else
    64'h636c617373,   // class
    64'h616e64        // and
  };

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_input;
  } stsc_in_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [15:0] line_number;
  } stsc_rec_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic        last;
  } stsc_out_t;

  // all records caused by one input byte
  typedef struct packed {
    logic [1:0]           count;
    stsc_rec_t [2:0]      recs;
  } stsc_bundle_t;

  function automatic logic [5:0] op_base(input logic [1:0] op);
    logic [5:0] k;
    unique case (op)
      OP_BANG:    k = K_BANG;
      OP_EQUAL:   k = K_EQUAL;
      OP_GREATER: k = K_GREATER;
      default:    k = K_LESS;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] word_kind(input logic [KW_BITS-1:0] p,
                                           input logic too_long);
    logic [5:0] k;
    k = K_IDENT;
    if (!too_long) begin
      for (int i = 0; i < 16; i++) begin
        if (KW_TABLE[i] == p) k = K_KW0 + 6'(i);
      end
    end
    return k;
  endfunction

endpackage
`default_nettype wire

// File: sv/script_token_scanner_top.sv
// Top level of the streaming script token scanner.
`timescale 1ns / 1ps
`default_nettype none
// Streaming lexical scanner: one source byte (or an end-of-input mark) per input
// transaction, token records (kind, start offset, length, line, last) per output
// transaction. The front end takes a byte every cycle while the bundle queue has
// room; each byte is classified in the cycle it is accepted and all records it
// causes (zero to three) go into the queue as one bundle. The sender drains one
// record per cycle while out_ready is high, so sustained rate is one byte per
// cycle as long as bytes average at most one record each; a byte that ends a
// number and a dot causes up to three records, absorbed by the four-entry queue.
// Records are registered in the queue before they are offered. Words longer
// than MAX_KEYWORD_LEN bytes are always identifiers; positions are OFFSET_BITS
// wide and saturate. After the end token nothing more is produced until reset.
module script_token_scanner_top
  import stsc_pkg::*;
#(
  parameter int OFFSET_BITS     = OFFSET_BITS_DEF,
  parameter int MAX_KEYWORD_LEN = MAX_KEYWORD_LEN_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire stsc_in_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output stsc_out_t     out_data
);

  logic         accept;
  logic         push;
  logic         pop;
  logic         full;
  logic         empty;
  stsc_bundle_t wr_bundle;
  stsc_bundle_t head;

  // take a byte whenever the queue can hold its bundle
  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  stsc_front #(
    .OFFSET_BITS     (OFFSET_BITS),
    .MAX_KEYWORD_LEN (MAX_KEYWORD_LEN)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_data),
    .push   (push),
    .bundle (wr_bundle)
  );

  // hold bundles so a stalled consumer does not stop the scan at once
  stsc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (wr_bundle),
    .pop     (pop),
    .full    (full),
    .empty   (empty),
    .head    (head)
  );

  // advance through the head bundle one record per transaction
  stsc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .have      (!empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// File: sv/stsc_front.sv
// Scanner front end: lexer state machine that turns each byte into a record bundle.
`timescale 1ns / 1ps
`default_nettype none
module stsc_front
  import stsc_pkg::*;
#(
  parameter int OFFSET_BITS     = OFFSET_BITS_DEF,
  parameter int MAX_KEYWORD_LEN = MAX_KEYWORD_LEN_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         accept,
  input  wire stsc_in_t     item,
  output logic              push,
  output stsc_bundle_t      bundle
);

  localparam int W  = OFFSET_BITS;
  localparam int LW = OFFSET_BITS + 1;
  localparam int PW = 8 * MAX_KEYWORD_LEN;

  typedef enum logic [3:0] {
    M_IDLE      = 4'd0,
    M_OPER      = 4'd1,
    M_SLASH     = 4'd2,
    M_LINECMT   = 4'd3,
    M_BLOCK     = 4'd4,
    M_BLOCKSTAR = 4'd5,
    M_INT       = 4'd6,
    M_DOT       = 4'd7,
    M_FRAC      = 4'd8,
    M_STRING    = 4'd9,
    M_IDENT     = 4'd10
  } mode_t;

  mode_t          mode_r, mode_nxt;
  logic [1:0]     op_r, op_nxt;
  logic [W-1:0]   pos_r, pos_nxt;
  logic [W-1:0]   start_r, start_nxt;
  logic [15:0]    line_r, line_nxt;
  logic [PW-1:0]  prefix_r, prefix_nxt;
  logic           too_long_r, too_long_nxt;
  logic           finished_r, finished_nxt;

  logic [7:0]     c;
  logic           eoi;
  logic [W-1:0]   pos_m1;
  logic [5:0]     wkind;

  // idle-byte decode
  mode_t          idl_mode;
  logic           idl_emit, idl_set_start, idl_oper, idl_word, idl_bump;
  logic [5:0]     idl_kind;
  logic [1:0]     idl_op;

  stsc_rec_t [2:0] recs;
  logic [1:0]     n;

  assign c      = item.ch;
  assign eoi    = item.end_of_input;
  assign pos_m1 = (pos_r != '0) ? pos_r - W'(1) : '0;
  assign wkind  = word_kind(KW_BITS'(prefix_r), too_long_r);

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic logic [W-1:0] span(input logic [W-1:0] from, input logic [W-1:0] to);
    return (to >= from) ? to - from : '0;
  endfunction

  function automatic stsc_rec_t mk_rec(input logic [5:0] k, input logic [W-1:0] s,
                                       input logic [LW-1:0] len, input logic [15:0] ln);
    stsc_rec_t  r;
    logic [32:0] lx;
    logic [32:0] sx;
    lx = 33'(len);
    sx = 33'(s);
    r.kind         = k;
    r.token_start  = sx[15:0];
    r.token_length = (lx > 33'h0FFFF) ? 16'hFFFF : lx[15:0];
    r.line_number  = ln;
    return r;
  endfunction

  always_comb begin
    idl_mode      = M_IDLE;
    idl_emit      = 1'b0;
    idl_kind      = K_BADCHAR;
    idl_set_start = 1'b0;
    idl_oper      = 1'b0;
    idl_op        = OP_BANG;
    idl_word      = 1'b0;
    idl_bump      = 1'b0;
    unique case (c)
      "(": begin idl_emit = 1'b1; idl_kind = K_LPAREN; end
      ")": begin idl_emit = 1'b1; idl_kind = K_RPAREN; end
      "{": begin idl_emit = 1'b1; idl_kind = K_LBRACE; end
      "}": begin idl_emit = 1'b1; idl_kind = K_RBRACE; end
      ",": begin idl_emit = 1'b1; idl_kind = K_COMMA; end
      ".": begin idl_emit = 1'b1; idl_kind = K_DOT; end
      "-": begin idl_emit = 1'b1; idl_kind = K_MINUS; end
      "+": begin idl_emit = 1'b1; idl_kind = K_PLUS; end
      ";": begin idl_emit = 1'b1; idl_kind = K_SEMI; end
      "*": begin idl_emit = 1'b1; idl_kind = K_STAR; end
      "!": begin idl_oper = 1'b1; idl_op = OP_BANG; end
      "=": begin idl_oper = 1'b1; idl_op = OP_EQUAL; end
      ">": begin idl_oper = 1'b1; idl_op = OP_GREATER; end
      "<": begin idl_oper = 1'b1; idl_op = OP_LESS; end
      "/": begin idl_set_start = 1'b1; idl_mode = M_SLASH; end
      " ", 8'h0d, 8'h09: ;
      8'h0a: idl_bump = 1'b1;
      8'h22: begin idl_set_start = 1'b1; idl_mode = M_STRING; end
      default: begin
        if (is_digit(c)) begin
          idl_set_start = 1'b1;
          idl_mode      = M_INT;
        end else if (is_alpha(c)) begin
          idl_set_start = 1'b1;
          idl_word      = 1'b1;
          idl_mode      = M_IDENT;
        end else begin
          idl_emit = 1'b1;
        end
      end
    endcase
    if (idl_oper) begin
      idl_set_start = 1'b1;
      idl_mode      = M_OPER;
    end
  end

  always_comb begin
    logic do_idle;
    logic bump;
    mode_nxt     = mode_r;
    op_nxt       = op_r;
    pos_nxt      = pos_r;
    start_nxt    = start_r;
    line_nxt     = line_r;
    prefix_nxt   = prefix_r;
    too_long_nxt = too_long_r;
    finished_nxt = finished_r;
    recs         = '0;
    n            = 2'd0;
    do_idle      = 1'b0;
    bump         = 1'b0;
    if (!finished_r) begin
      if (eoi) begin
        unique case (mode_r)
          M_OPER: begin
            recs[n] = mk_rec(op_base(op_r), start_r, LW'(span(start_r, pos_r)), line_r);
            n = n + 2'd1;
          end
          M_SLASH: begin
            recs[n] = mk_rec(K_SLASH, start_r, LW'(span(start_r, pos_r)), line_r);
            n = n + 2'd1;
          end
          M_INT, M_FRAC: begin
            recs[n] = mk_rec(K_NUMBER, start_r, LW'(span(start_r, pos_r)), line_r);
            n = n + 2'd1;
          end
          M_DOT: begin
            recs[n] = mk_rec(K_NUMBER, start_r, LW'(span(start_r, pos_m1)), line_r);
            n = n + 2'd1;
            recs[n] = mk_rec(K_DOT, pos_m1, LW'(1), line_r);
            n = n + 2'd1;
          end
          M_STRING: begin
            recs[n] = mk_rec(K_UNTERM, start_r, LW'(span(start_r, pos_r)), line_r);
            n = n + 2'd1;
          end
          M_IDENT: begin
            recs[n] = mk_rec(wkind, start_r, LW'(span(start_r, pos_r)), line_r);
            n = n + 2'd1;
          end
          default: ;
        endcase
        recs[n]      = mk_rec(K_END, pos_r, '0, line_r);
        n            = n + 2'd1;
        mode_nxt     = M_IDLE;
        finished_nxt = 1'b1;
      end else begin
        unique case (mode_r)
          M_OPER: begin
            if (c == "=") begin
              recs[n] = mk_rec(op_base(op_r) + 6'd1, start_r,
                               LW'(span(start_r, pos_r)) + LW'(1), line_r);
              n = n + 2'd1;
              mode_nxt = M_IDLE;
            end else begin
              recs[n] = mk_rec(op_base(op_r), start_r, LW'(span(start_r, pos_r)), line_r);
              n = n + 2'd1;
              do_idle = 1'b1;
            end
          end
          M_SLASH: begin
            if (c == "/") mode_nxt = M_LINECMT;
            else if (c == "*") mode_nxt = M_BLOCK;
            else begin
              recs[n] = mk_rec(K_SLASH, start_r, LW'(span(start_r, pos_r)), line_r);
              n = n + 2'd1;
              do_idle = 1'b1;
            end
          end
          M_LINECMT: begin
            if (c == 8'h0a) do_idle = 1'b1;
          end
          M_BLOCK: begin
            if (c == "*") mode_nxt = M_BLOCKSTAR;
          end
          M_BLOCKSTAR: begin
            if (c == "/") mode_nxt = M_IDLE;
            else if (c != "*") mode_nxt = M_BLOCK;
          end
          M_INT: begin
            if (c == ".") mode_nxt = M_DOT;
            else if (!is_digit(c)) begin
              recs[n] = mk_rec(K_NUMBER, start_r, LW'(span(start_r, pos_r)), line_r);
              n = n + 2'd1;
              do_idle = 1'b1;
            end
          end
          M_DOT: begin
            if (is_digit(c)) mode_nxt = M_FRAC;
            else begin
              recs[n] = mk_rec(K_NUMBER, start_r, LW'(span(start_r, pos_m1)), line_r);
              n = n + 2'd1;
              recs[n] = mk_rec(K_DOT, pos_m1, LW'(1), line_r);
              n = n + 2'd1;
              do_idle = 1'b1;
            end
          end
          M_FRAC: begin
            if (!is_digit(c)) begin
              recs[n] = mk_rec(K_NUMBER, start_r, LW'(span(start_r, pos_r)), line_r);
              n = n + 2'd1;
              do_idle = 1'b1;
            end
          end
          M_STRING: begin
            if (c == 8'h22) begin
              recs[n] = mk_rec(K_STRING, start_r,
                               LW'(span(start_r, pos_r)) + LW'(1), line_r);
              n = n + 2'd1;
              mode_nxt = M_IDLE;
            end else if (c == 8'h0a) begin
              bump = 1'b1;
            end
          end
          M_IDENT: begin
            if (is_alpha(c) || is_digit(c)) begin
              too_long_nxt = too_long_r | (prefix_r[PW-1 -: 8] != 8'd0);
              prefix_nxt   = {prefix_r[PW-9:0], c};
            end else begin
              recs[n] = mk_rec(wkind, start_r, LW'(span(start_r, pos_r)), line_r);
              n = n + 2'd1;
              do_idle = 1'b1;
            end
          end
          default: do_idle = 1'b1;
        endcase
        if (do_idle) begin
          mode_nxt = idl_mode;
          if (idl_set_start) start_nxt = pos_r;
          if (idl_oper) op_nxt = idl_op;
          if (idl_word) begin
            prefix_nxt   = PW'(c);
            too_long_nxt = 1'b0;
          end
          if (idl_bump) bump = 1'b1;
          if (idl_emit) begin
            recs[n] = mk_rec(idl_kind, pos_r, LW'(1), line_r);
            n = n + 2'd1;
          end
        end
        if (bump && line_r != 16'hFFFF) line_nxt = line_r + 16'd1;
        if (pos_r != '1) pos_nxt = pos_r + W'(1);
      end
    end
  end

  assign push          = accept && (n != 2'd0);
  assign bundle.count  = n;
  assign bundle.recs   = recs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= M_IDLE;
      op_r       <= OP_BANG;
      pos_r      <= '0;
      start_r    <= '0;
      line_r     <= 16'd1;
      prefix_r   <= '0;
      too_long_r <= 1'b0;
      finished_r <= 1'b0;
    end else if (accept) begin
      mode_r     <= mode_nxt;
      op_r       <= op_nxt;
      pos_r      <= pos_nxt;
      start_r    <= start_nxt;
      line_r     <= line_nxt;
      prefix_r   <= prefix_nxt;
      too_long_r <= too_long_nxt;
      finished_r <= finished_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/stsc_queue.sv
// Short bundle queue between the scanner front end and the record sender.
`timescale 1ns / 1ps
`default_nettype none
module stsc_queue
  import stsc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire stsc_bundle_t wr_data,
  input  wire logic         pop,
  output logic              full,
  output logic              empty,
  output stsc_bundle_t      head
);

  stsc_bundle_t          mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]     count_r;

  assign full  = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QUEUE_AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QUEUE_AW'(1);
      if (push && !pop)      count_r <= count_r + (QUEUE_AW+1)'(1);
      else if (pop && !push) count_r <= count_r - (QUEUE_AW+1)'(1);
    end
  end

endmodule
`default_nettype wire

// File: sv/stsc_back.sv
// Record sender: walks the head bundle and hands out one token record per transaction.
`timescale 1ns / 1ps
`default_nettype none
module stsc_back
  import stsc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         have,
  input  wire stsc_bundle_t head,
  output logic              pop,
  output logic              out_valid,
  input  wire logic         out_ready,
  output stsc_out_t         out_data
);

  logic [1:0] idx_r;
  logic       is_last;
  stsc_rec_t  rec;

  assign rec       = head.recs[idx_r];
  assign is_last   = (idx_r == head.count - 2'd1);
  assign out_valid = have;
  assign out_data  = '{kind: rec.kind, token_start: rec.token_start,
                       token_length: rec.token_length, line_number: rec.line_number,
                       last: is_last};
  assign pop       = have && out_ready && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else if (have && out_ready) begin
      idx_r <= is_last ? 2'd0 : idx_r + 2'd1;
    end
  end

endmodule
`default_nettype wire
